FILE: rtl/prg_pkg.sv
package prg_pkg;

    localparam int MAX_DIM    = 8192;

    localparam int DIM_W      = 14;
    localparam int PIX_W      = 13;
    localparam int JIT_W      = 16;
    localparam int DIR_W      = 16;
    localparam int VEC_W      = 63;
    localparam int COMP_W     = 21;
    localparam int PS_W       = 32;
    localparam int PS_HALF_W  = PS_W / 2;
    localparam int IDX_W      = 3;

    // datapath widths
    localparam int OFS_W      = 30;                 // offsets, Q.15 pixels
    localparam int PP_W       = OFS_W + PS_HALF_W + 1;
    localparam int UVS_W      = OFS_W + PS_W + 1;
    localparam int UV_W       = 34;                 // u, v in Q.18
    localparam int PROD_W     = COMP_W + UV_W;
    localparam int D_W        = 57;                 // direction, Q.36
    localparam int M_W        = 30;                 // normalised magnitude
    localparam int SQT_W      = 2 * M_W;
    localparam int SS_W       = 62;
    localparam int N_W        = 31;
    localparam int NUM_W      = M_W + 17;
    localparam int DEN_W      = N_W + 1;
    localparam int Q_W        = 17;

    localparam int BASIS_FRAC = 18;
    localparam int HALF_PIX   = 1 << 14;
    localparam int PIX_SH     = 15;
    localparam int DIM_SH     = 14;
    localparam int UV_SH      = 29;
    localparam int QUO_SH     = 16;
    localparam int NRM_N      = 6;
    localparam int NRM_MAX    = 32;
    localparam int SQ_N       = SS_W / 2;
    localparam int DV_N       = Q_W;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int OQ_DEPTH   = 2;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [IDX_W-1:0] REG_FWD   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEFT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_UP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_PSIZE = 3'd3;
    localparam logic [IDX_W-1:0] REG_W     = 3'd4;
    localparam logic [IDX_W-1:0] REG_H     = 3'd5;
    localparam logic [IDX_W-1:0] REG_JEN   = 3'd6;

    typedef struct packed {
        logic [VEC_W-1:0] fwd;
        logic [VEC_W-1:0] left;
        logic [VEC_W-1:0] up;
        logic [PS_W-1:0]  psize;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             jit_en;
    } cfg_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] ou;
        logic signed [OFS_W-1:0] ov;
    } ofs_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
        logic                    zero;
    } res_t;

    function automatic logic signed [COMP_W-1:0] vcomp(input logic [VEC_W-1:0] vec,
                                                       input int k);
        return signed'(vec[COMP_W*k +: COMP_W]);
    endfunction

endpackage

FILE: rtl/prg_front.sv
module prg_front
    import prg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VEC_W-1:0]        cfg_data,
    input  logic [PIX_W-1:0]        pixel_x,
    input  logic [PIX_W-1:0]        pixel_y,
    input  logic signed [JIT_W-1:0] jitter_x,
    input  logic signed [JIT_W-1:0] jitter_y,
    input  logic                    want_jitter,
    output cfg_t                    cfg,
    output ofs_t                    ofs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                    jit;
    logic [DIM_W-1:0]        w_cl;
    logic [DIM_W-1:0]        h_cl;
    logic signed [OFS_W-1:0] jx;
    logic signed [OFS_W-1:0] jy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FWD:   cfg_next.fwd    = cfg_data;
                REG_LEFT:  cfg_next.left   = cfg_data;
                REG_UP:    cfg_next.up     = cfg_data;
                REG_PSIZE: cfg_next.psize  = cfg_data[PS_W-1:0];
                REG_W:     cfg_next.w      = cfg_data[DIM_W-1:0];
                REG_H:     cfg_next.h      = cfg_data[DIM_W-1:0];
                REG_JEN:   cfg_next.jit_en = cfg_data[0];
                default:   cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            cfg_reg.w      <= DIM_W'(2);
            cfg_reg.h      <= DIM_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // offsets from the pixel centre in Q.15 pixels
    always_comb
    begin
        jit  = cfg_reg.jit_en && want_jitter;
        w_cl = (cfg_reg.w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_reg.w;
        h_cl = (cfg_reg.h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_reg.h;
        jx   = jit ? OFS_W'(jitter_x) : '0;
        jy   = jit ? OFS_W'(jitter_y) : '0;
        ofs.ou = signed'(OFS_W'(w_cl) << DIM_SH) - signed'(OFS_W'(pixel_x) << PIX_SH)
               - OFS_W'(HALF_PIX) + jx;
        ofs.ov = signed'(OFS_W'(h_cl) << DIM_SH) - signed'(OFS_W'(pixel_y) << PIX_SH)
               - OFS_W'(HALF_PIX) + jy;
    end

endmodule

FILE: rtl/prg_queue.sv
module prg_queue
    import prg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ofs_t wdata,
    output logic full,
    input  logic pop,
    output ofs_t rdata,
    output logic empty
);

    ofs_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg;
    logic [Q_PTR_W-1:0] rd_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/prg_sqrt.sv
module prg_sqrt
    import prg_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [SS_W-1:0] rad,
    output logic [N_W-1:0]  root
);

    localparam int REM_W = N_W + 3;

    logic [SS_W-1:0]  rad_reg  [SQ_N];
    logic [REM_W-1:0] rem_reg  [SQ_N];
    logic [N_W-1:0]   root_reg [SQ_N];

    logic [SS_W-1:0]  src_rad  [SQ_N];
    logic [REM_W-1:0] src_rem  [SQ_N];
    logic [N_W-1:0]   src_root [SQ_N];
    logic [REM_W-1:0] trial    [SQ_N];
    logic [REM_W-1:0] test     [SQ_N];

    // one root bit per stage, two radicand bits brought down each time
    always_comb
    begin
        src_rad[0]  = rad;
        src_rem[0]  = '0;
        src_root[0] = '0;
        for (int k = 1; k < SQ_N; k++)
        begin
            src_rad[k]  = rad_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_root[k] = root_reg[k-1];
        end
        for (int k = 0; k < SQ_N; k++)
        begin
            trial[k] = {src_rem[k][REM_W-3:0], src_rad[k][SS_W-1 -: 2]};
            test[k]  = {1'b0, src_root[k], 2'b01};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_N; k++)
            begin
                rad_reg[k] <= src_rad[k] << 2;
                if (trial[k] >= test[k])
                begin
                    rem_reg[k]  <= trial[k] - test[k];
                    root_reg[k] <= {src_root[k][N_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= trial[k];
                    root_reg[k] <= {src_root[k][N_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SQ_N-1];

endmodule

FILE: rtl/prg_div.sv
module prg_div
    import prg_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int R_W = NUM_W + 1;

    logic [R_W-1:0]   r_reg [DV_N];
    logic [Q_W-1:0]   q_reg [DV_N];
    logic [DEN_W-1:0] d_reg [DV_N];

    logic [R_W-1:0]   src_r [DV_N];
    logic [Q_W-1:0]   src_q [DV_N];
    logic [DEN_W-1:0] src_d [DV_N];
    logic [R_W-1:0]   sub   [DV_N];
    logic             ge    [DV_N];

    // restoring division, quotient msb first, one bit per stage
    always_comb
    begin
        src_r[0] = R_W'(num);
        src_q[0] = '0;
        src_d[0] = den;
        for (int k = 1; k < DV_N; k++)
        begin
            src_r[k] = r_reg[k-1];
            src_q[k] = q_reg[k-1];
            src_d[k] = d_reg[k-1];
        end
        for (int k = 0; k < DV_N; k++)
        begin
            sub[k] = R_W'(src_d[k]) << (Q_W - 1 - k);
            ge[k]  = (src_r[k] >= sub[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DV_N; k++)
            begin
                r_reg[k] <= ge[k] ? (src_r[k] - sub[k]) : src_r[k];
                q_reg[k] <= {src_q[k][Q_W-2:0], ge[k]};
                d_reg[k] <= src_d[k];
            end
        end
    end

    assign quo = q_reg[DV_N-1];

endmodule

FILE: rtl/prg_back.sv
module prg_back
    import prg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  ofs_t q_data,
    output logic q_pop,
    output res_t res,
    output logic res_empty,
    input  logic res_pop
);

    localparam int PIPE_N = 5 + NRM_N + 2 + SQ_N + DV_N;

    logic                adv;
    logic [PIPE_N-1:0]   vld_reg;

    // stage 1: offset times pixel size, in two halves
    logic signed [PP_W-1:0]   s1_ulo_reg, s1_uhi_reg, s1_vlo_reg, s1_vhi_reg;
    // stage 2: u, v
    logic signed [UVS_W-1:0]  u_sum, v_sum;
    logic signed [UV_W-1:0]   s2_u_reg, s2_v_reg;
    // stage 3: basis products
    logic signed [PROD_W-1:0] s3_lu_reg [3];
    logic signed [PROD_W-1:0] s3_uv_reg [3];
    // stage 4: direction magnitudes
    logic signed [D_W-1:0]    d4 [3];
    logic [D_W-1:0]           s4_mag_reg [3];
    logic [2:0]               s4_neg_reg;
    // stage 5: largest magnitude
    logic [D_W-1:0]           e5;
    logic [D_W-1:0]           s5_e_reg;
    logic [D_W-1:0]           s5_mag_reg [3];
    logic [2:0]               s5_neg_reg;
    logic                     s5_zero_reg;
    // normalising shifter
    logic [D_W-1:0]           ne_reg [NRM_N];
    logic [D_W-1:0]           nm_reg [NRM_N][3];
    logic [2:0]               nneg_reg [NRM_N];
    logic                     nzero_reg [NRM_N];
    logic [D_W-1:0]           src_e [NRM_N];
    logic [D_W-1:0]           src_m [NRM_N][3];
    logic [2:0]               src_neg [NRM_N];
    logic                     src_zero [NRM_N];
    logic                     hit [NRM_N];
    // squares and their sum
    logic [M_W-1:0]           m30 [3];
    logic [SQT_W-1:0]         sq_reg [3];
    logic [M_W-1:0]           sq_m_reg [3];
    logic [2:0]               sq_neg_reg;
    logic                     sq_zero_reg;
    logic [SS_W-1:0]          ss_reg;
    logic [M_W-1:0]           ss_m_reg [3];
    logic [2:0]               ss_neg_reg;
    logic                     ss_zero_reg;
    // side data beside the root and the dividers
    logic [M_W-1:0]           sd_m_reg [SQ_N][3];
    logic [2:0]               sd_neg_reg [SQ_N + DV_N];
    logic                     sd_zero_reg [SQ_N + DV_N];

    logic [N_W-1:0]           root;
    logic [NUM_W-1:0]         num [3];
    logic [DEN_W-1:0]         den;
    logic [Q_W-1:0]           quo [3];
    logic [Q_W-1:0]           qs [3];
    logic [DIR_W-1:0]         rc [3];
    logic [2:0]               fneg;
    logic                     fzero;
    res_t                     res_in;

    // result queue
    res_t                     oq_mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]      oq_wr_reg;
    logic [OQ_PTR_W-1:0]      oq_rd_reg;
    logic [OQ_CNT_W-1:0]      oq_cnt_reg;
    logic                     oq_push;
    logic                     oq_pop;

    assign adv   = (oq_cnt_reg != OQ_CNT_W'(OQ_DEPTH));
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        u_sum = (UVS_W'(s1_uhi_reg) <<< PS_HALF_W) + UVS_W'(s1_ulo_reg)
              + UVS_W'(1 << (UV_SH - 1));
        v_sum = (UVS_W'(s1_vhi_reg) <<< PS_HALF_W) + UVS_W'(s1_vlo_reg)
              + UVS_W'(1 << (UV_SH - 1));
        for (int k = 0; k < 3; k++)
        begin
            d4[k] = (D_W'(vcomp(cfg.fwd, k)) <<< BASIS_FRAC) + D_W'(s3_lu_reg[k])
                  + D_W'(s3_uv_reg[k]);
        end
        e5 = (s4_mag_reg[0] > s4_mag_reg[1]) ? s4_mag_reg[0] : s4_mag_reg[1];
        if (s4_mag_reg[2] > e5)
        begin
            e5 = s4_mag_reg[2];
        end
    end

    // left-justify the largest magnitude; the top M_W bits are then taken
    always_comb
    begin
        src_e[0]    = s5_e_reg;
        src_neg[0]  = s5_neg_reg;
        src_zero[0] = s5_zero_reg;
        for (int k = 0; k < 3; k++)
        begin
            src_m[0][k] = s5_mag_reg[k];
        end
        for (int j = 1; j < NRM_N; j++)
        begin
            src_e[j]    = ne_reg[j-1];
            src_neg[j]  = nneg_reg[j-1];
            src_zero[j] = nzero_reg[j-1];
            for (int k = 0; k < 3; k++)
            begin
                src_m[j][k] = nm_reg[j-1][k];
            end
        end
        for (int j = 0; j < NRM_N; j++)
        begin
            hit[j] = ((src_e[j] >> (D_W - (NRM_MAX >> j))) == '0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m30[k] = nm_reg[NRM_N-1][k][D_W-1 -: M_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ulo_reg <= PP_W'(q_data.ou) * PP_W'(signed'({1'b0, cfg.psize[PS_HALF_W-1:0]}));
            s1_uhi_reg <= PP_W'(q_data.ou) * PP_W'(signed'({1'b0, cfg.psize[PS_W-1:PS_HALF_W]}));
            s1_vlo_reg <= PP_W'(q_data.ov) * PP_W'(signed'({1'b0, cfg.psize[PS_HALF_W-1:0]}));
            s1_vhi_reg <= PP_W'(q_data.ov) * PP_W'(signed'({1'b0, cfg.psize[PS_W-1:PS_HALF_W]}));

            s2_u_reg <= UV_W'(u_sum >>> UV_SH);
            s2_v_reg <= UV_W'(v_sum >>> UV_SH);

            for (int k = 0; k < 3; k++)
            begin
                s3_lu_reg[k] <= PROD_W'(vcomp(cfg.left, k)) * PROD_W'(s2_u_reg);
                s3_uv_reg[k] <= PROD_W'(vcomp(cfg.up, k)) * PROD_W'(s2_v_reg);
                s4_neg_reg[k] <= d4[k][D_W-1];
                s4_mag_reg[k] <= d4[k][D_W-1] ? unsigned'(-d4[k]) : unsigned'(d4[k]);
                s5_mag_reg[k] <= s4_mag_reg[k];
            end
            s5_e_reg    <= e5;
            s5_neg_reg  <= s4_neg_reg;
            s5_zero_reg <= (e5 == '0);

            for (int j = 0; j < NRM_N; j++)
            begin
                ne_reg[j]    <= hit[j] ? (src_e[j] << (NRM_MAX >> j)) : src_e[j];
                nneg_reg[j]  <= src_neg[j];
                nzero_reg[j] <= src_zero[j];
                for (int k = 0; k < 3; k++)
                begin
                    nm_reg[j][k] <= hit[j] ? (src_m[j][k] << (NRM_MAX >> j)) : src_m[j][k];
                end
            end

            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]   <= SQT_W'(m30[k]) * SQT_W'(m30[k]);
                sq_m_reg[k] <= m30[k];
                ss_m_reg[k] <= sq_m_reg[k];
            end
            sq_neg_reg  <= nneg_reg[NRM_N-1];
            sq_zero_reg <= nzero_reg[NRM_N-1];
            ss_reg      <= SS_W'(sq_reg[0]) + SS_W'(sq_reg[1]) + SS_W'(sq_reg[2]);
            ss_neg_reg  <= sq_neg_reg;
            ss_zero_reg <= sq_zero_reg;

            for (int k = 0; k < 3; k++)
            begin
                sd_m_reg[0][k] <= ss_m_reg[k];
                for (int j = 1; j < SQ_N; j++)
                begin
                    sd_m_reg[j][k] <= sd_m_reg[j-1][k];
                end
            end
            sd_neg_reg[0]  <= ss_neg_reg;
            sd_zero_reg[0] <= ss_zero_reg;
            for (int j = 1; j < SQ_N + DV_N; j++)
            begin
                sd_neg_reg[j]  <= sd_neg_reg[j-1];
                sd_zero_reg[j] <= sd_zero_reg[j-1];
            end
        end
    end

    prg_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (ss_reg),
        .root (root)
    );

    assign den = {root, 1'b0};

    generate
        for (genvar g = 0; g < 3; g++)
        begin : g_div
            assign num[g] = (NUM_W'(sd_m_reg[SQ_N-1][g]) << QUO_SH) + NUM_W'(root);

            prg_div u_div (
                .clk (clk),
                .en  (adv),
                .num (num[g]),
                .den (den),
                .quo (quo[g])
            );
        end
    endgenerate

    // saturate and apply signs
    always_comb
    begin
        fneg  = sd_neg_reg[SQ_N+DV_N-1];
        fzero = sd_zero_reg[SQ_N+DV_N-1];
        for (int k = 0; k < 3; k++)
        begin
            if (fneg[k])
            begin
                qs[k] = (quo[k] > Q_W'(32768)) ? Q_W'(32768) : quo[k];
                rc[k] = DIR_W'(-qs[k]);
            end
            else
            begin
                qs[k] = (quo[k] > Q_W'(32767)) ? Q_W'(32767) : quo[k];
                rc[k] = qs[k][DIR_W-1:0];
            end
        end
        res_in.x    = fzero ? '0 : signed'(rc[0]);
        res_in.y    = fzero ? '0 : signed'(rc[1]);
        res_in.z    = fzero ? '0 : signed'(rc[2]);
        res_in.zero = fzero;
    end

    assign oq_push   = adv && vld_reg[PIPE_N-1];
    assign res_empty = (oq_cnt_reg == '0);
    assign oq_pop    = res_pop && !res_empty;
    assign res       = oq_mem_reg[oq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem_reg[oq_wr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[PIPE_N-2:0], !q_empty};
            end
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(1);
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - OQ_CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/pinhole_primary_ray_generator.sv
// channel   | handshake       | beat carries
// ----------+-----------------+--------------------------------------------------
// pixel in  | push / full     | pixel_x, pixel_y, jitter_x, jitter_y, want_jitter
// ray out   | empty / pop     | dir_x, dir_y, dir_z, zero_length
// config    | cfg_we          | cfg_index, cfg_data (no read-back)
//
// One beat per cycle in and out while the result queue has room; the back-end
// pipeline holds the 31-stage square root and the 17-stage dividers.
// rst_n clears the queues and valid line; registers return to their defaults.
// The back end stalls as a whole only when the two-entry result queue is full;
// the four-entry offset queue lets the front keep taking beats meanwhile.
module pinhole_primary_ray_generator
    import prg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VEC_W-1:0]        cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [PIX_W-1:0]        pixel_x,
    input  logic [PIX_W-1:0]        pixel_y,
    input  logic signed [JIT_W-1:0] jitter_x,
    input  logic signed [JIT_W-1:0] jitter_y,
    input  logic                    want_jitter,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [DIR_W-1:0] dir_x,
    output logic signed [DIR_W-1:0] dir_y,
    output logic signed [DIR_W-1:0] dir_z,
    output logic                    zero_length
);

    cfg_t cfg;
    ofs_t ofs_in;
    ofs_t ofs_out;
    logic q_empty;
    logic q_pop;
    res_t res;

    prg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .jitter_x    (jitter_x),
        .jitter_y    (jitter_y),
        .want_jitter (want_jitter),
        .cfg         (cfg),
        .ofs         (ofs_in)
    );

    prg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (ofs_in),
        .full  (full),
        .pop   (q_pop),
        .rdata (ofs_out),
        .empty (q_empty)
    );

    prg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (ofs_out),
        .q_pop     (q_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign dir_x       = res.x;
    assign dir_y       = res.y;
    assign dir_z       = res.z;
    assign zero_length = res.zero;

endmodule

FILE: rtl/prg_checker.sv
module prg_checker
    import prg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cfg_we,
    input logic [IDX_W-1:0]        cfg_index,
    input logic [VEC_W-1:0]        cfg_data,
    input logic                    push,
    input logic                    full,
    input logic [PIX_W-1:0]        pixel_x,
    input logic [PIX_W-1:0]        pixel_y,
    input logic signed [JIT_W-1:0] jitter_x,
    input logic signed [JIT_W-1:0] jitter_y,
    input logic                    want_jitter,
    input logic                    empty,
    input logic                    pop,
    input logic signed [DIR_W-1:0] dir_x,
    input logic signed [DIR_W-1:0] dir_y,
    input logic signed [DIR_W-1:0] dir_z,
    input logic                    zero_length
);

    // a waiting beat is not withdrawn
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat withdrawn");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(dir_x) && $stable(dir_y) && $stable(dir_z)
                              && $stable(zero_length)))
        else $error("stalled result beat changed");

    // degenerate direction reads as all zero
    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_length) |-> (dir_x == '0 && dir_y == '0 && dir_z == '0))
        else $error("zero-length ray with non-zero direction");

    // a normalised direction always has a non-zero component
    a_unit_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !zero_length) |-> !(dir_x == '0 && dir_y == '0 && dir_z == '0))
        else $error("normalised direction is zero");

endmodule

bind pinhole_primary_ray_generator prg_checker u_prg_checker (.*);
